// ----- design/ezr_pkg.sv -----
`default_nettype none

package ezr_pkg;

  localparam int CordicStepsDefault = 24;
  localparam int VectorWidthDefault = 32;

  // angle and trig widths
  localparam int AW = 17;   // reduced angle in hundredths of a degree
  localparam int ZW = 34;   // cordic residual angle, Q2.30 with headroom
  localparam int CW = 34;   // cordic x and y, Q1.30 with headroom
  localparam int TW = 32;   // sine and cosine, Q1.30
  localparam int MW = 33;   // matrix coefficients, Q1.30 plus sum headroom
  localparam int VW = 32;   // vector components, Q16.16

  localparam int HalfTurn    = 18000;
  localparam int FullTurn    = 36000;
  localparam int QuarterTurn = 9000;

  // pi * 2^30 = ZInt * HalfTurn + ZFrac
  localparam int ZInt  = 187403;
  localparam int ZFrac = 5426;
  // floor(2^40 / HalfTurn)
  localparam logic [25:0] RecipQ40 = 26'd61083979;
  localparam int RecipShift = 40;

  localparam logic [30:0] GainQ30 = 31'd652032874;

  typedef struct packed {
    logic            to_body;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } side_t;

  // truncated Q1.30 arctangent of 2^-i
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] r;
    case (i)
      0:  r = 31'd843314856;
      1:  r = 31'd497837829;
      2:  r = 31'd263043836;
      3:  r = 31'd133525158;
      4:  r = 31'd67021686;
      5:  r = 31'd33543515;
      6:  r = 31'd16775850;
      7:  r = 31'd8388437;
      8:  r = 31'd4194282;
      9:  r = 31'd2097149;
      10: r = 31'd1048575;
      11: r = 31'd524287;
      12: r = 31'd262143;
      13: r = 31'd131071;
      14: r = 31'd65535;
      15: r = 31'd32767;
      16: r = 31'd16383;
      17: r = 31'd8191;
      18: r = 31'd4095;
      19: r = 31'd2047;
      20: r = 31'd1023;
      21: r = 31'd511;
      22: r = 31'd255;
      23: r = 31'd127;
      24: r = 31'd63;
      25: r = 31'd31;
      26: r = 31'd15;
      27: r = 31'd8;
      28: r = 31'd4;
      29: r = 31'd2;
      30: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  // Q1.30 product rounded half up
  function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = (2*TW)'(a) * (2*TW)'(b);
    p = p + $signed({{(2*TW-30){1'b0}}, 1'b1, 29'd0});
    return p[TW+29:30];
  endfunction

endpackage

`default_nettype wire

// ----- design/ezr_angle.sv -----
`default_nettype none

module ezr_angle import ezr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [15:0]   ang_i [3],
  output logic                 valid_o,
  output side_t                side_o,
  output logic signed [ZW-1:0] z_o [3],
  output logic                 flip_o [3]
);

  // stage a: reduction and split of the constant product
  logic        va_q;
  side_t       sa_q;
  logic [31:0] p1_q [3];
  logic [25:0] t2_q [3];
  logic        neg_a_q [3];
  logic        flip_a_q [3];

  logic [31:0] p1_d [3];
  logic [25:0] t2_d [3];
  logic        neg_d [3];
  logic        flip_d [3];

  always_comb begin
    logic signed [AW-1:0] a;
    logic signed [AW-1:0] m;
    logic [13:0] mag;
    for (int l = 0; l < 3; l++) begin
      a = {ang_i[l][15], ang_i[l]};
      if (a >= AW'(HalfTurn)) begin
        a = a - AW'(FullTurn);
      end else if (a < -AW'(HalfTurn)) begin
        a = a + AW'(FullTurn);
      end
      flip_d[l] = 1'b0;
      if (a > AW'(QuarterTurn)) begin
        a = a - AW'(HalfTurn);
        flip_d[l] = 1'b1;
      end else if (a < -AW'(QuarterTurn)) begin
        a = a + AW'(HalfTurn);
        flip_d[l] = 1'b1;
      end
      neg_d[l] = a[AW-1];
      m = neg_d[l] ? -a : a;
      mag = m[13:0];
      p1_d[l] = 32'(mag) * 32'(ZInt);
      t2_d[l] = 26'(mag) * 26'(ZFrac) + 26'(HalfTurn / 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= side_i;
      for (int l = 0; l < 3; l++) begin
        p1_q[l]     <= p1_d[l];
        t2_q[l]     <= t2_d[l];
        neg_a_q[l]  <= neg_d[l];
        flip_a_q[l] <= flip_d[l];
      end
    end
  end

  // stage b: quotient estimate by reciprocal
  logic        vb_q;
  side_t       sb_q;
  logic [31:0] p1_b_q [3];
  logic [25:0] t2_b_q [3];
  logic [11:0] q_b_q [3];
  logic        neg_b_q [3];
  logic        flip_b_q [3];

  logic [11:0] q_d [3];

  always_comb begin
    logic [51:0] prod;
    for (int l = 0; l < 3; l++) begin
      prod = 52'(t2_q[l]) * 52'(RecipQ40);
      q_d[l] = prod[RecipShift+11:RecipShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q <= sa_q;
      for (int l = 0; l < 3; l++) begin
        p1_b_q[l]   <= p1_q[l];
        t2_b_q[l]   <= t2_q[l];
        q_b_q[l]    <= q_d[l];
        neg_b_q[l]  <= neg_a_q[l];
        flip_b_q[l] <= flip_a_q[l];
      end
    end
  end

  // stage c: quotient correction and signed radians
  logic        vc_q;
  side_t       sc_q;
  logic signed [ZW-1:0] z_q [3];
  logic        flip_c_q [3];

  logic signed [ZW-1:0] z_d [3];

  always_comb begin
    logic [25:0] r;
    logic [11:0] qc;
    logic signed [ZW-1:0] zm;
    for (int l = 0; l < 3; l++) begin
      r  = t2_b_q[l] - 26'(q_b_q[l]) * 26'(HalfTurn);
      qc = (r >= 26'(HalfTurn)) ? q_b_q[l] + 12'd1 : q_b_q[l];
      zm = $signed(ZW'(p1_b_q[l]) + ZW'(qc));
      z_d[l] = neg_b_q[l] ? -zm : zm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= sb_q;
      for (int l = 0; l < 3; l++) begin
        z_q[l]      <= z_d[l];
        flip_c_q[l] <= flip_b_q[l];
      end
    end
  end

  assign valid_o = vc_q;
  assign side_o  = sc_q;
  assign z_o     = z_q;
  assign flip_o  = flip_c_q;

endmodule

`default_nettype wire

// ----- design/ezr_cordic.sv -----
`default_nettype none

module ezr_cordic import ezr_pkg::*; #(
  parameter int CordicSteps = CordicStepsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [ZW-1:0] z_i [3],
  input  logic                 flip_i [3],
  output logic                 valid_o,
  output side_t                side_o,
  output logic signed [TW-1:0] sin_o [3],
  output logic signed [TW-1:0] cos_o [3]
);

  logic                 v_q [CordicSteps];
  side_t                s_q [CordicSteps];
  logic signed [CW-1:0] x_q [CordicSteps][3];
  logic signed [CW-1:0] y_q [CordicSteps][3];
  logic signed [ZW-1:0] z_q [CordicSteps][3];
  logic                 f_q [CordicSteps][3];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_stage
    localparam logic signed [ZW-1:0] Atan = $signed(ZW'(atan_q30(i)));

    logic                 vs;
    side_t                ss;
    logic signed [CW-1:0] xs [3];
    logic signed [CW-1:0] ys [3];
    logic signed [ZW-1:0] zs [3];
    logic                 fs [3];

    if (i == 0) begin : g_first
      always_comb begin
        vs = valid_i;
        ss = side_i;
        for (int l = 0; l < 3; l++) begin
          xs[l] = $signed(CW'(GainQ30));
          ys[l] = '0;
          zs[l] = z_i[l];
          fs[l] = flip_i[l];
        end
      end
    end else begin : g_next
      always_comb begin
        vs = v_q[i-1];
        ss = s_q[i-1];
        for (int l = 0; l < 3; l++) begin
          xs[l] = x_q[i-1][l];
          ys[l] = y_q[i-1][l];
          zs[l] = z_q[i-1][l];
          fs[l] = f_q[i-1][l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= vs;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i] <= ss;
        for (int l = 0; l < 3; l++) begin
          f_q[i][l] <= fs[l];
          if (!zs[l][ZW-1]) begin
            x_q[i][l] <= xs[l] - (ys[l] >>> i);
            y_q[i][l] <= ys[l] + (xs[l] >>> i);
            z_q[i][l] <= zs[l] - Atan;
          end else begin
            x_q[i][l] <= xs[l] + (ys[l] >>> i);
            y_q[i][l] <= ys[l] - (xs[l] >>> i);
            z_q[i][l] <= zs[l] + Atan;
          end
        end
      end
    end
  end

  // residual angle of the last stage is not needed
  always_comb begin
    logic signed [CW-1:0] xc;
    logic signed [CW-1:0] ysn;
    for (int l = 0; l < 3; l++) begin
      xc  = f_q[CordicSteps-1][l] ? -x_q[CordicSteps-1][l] : x_q[CordicSteps-1][l];
      ysn = f_q[CordicSteps-1][l] ? -y_q[CordicSteps-1][l] : y_q[CordicSteps-1][l];
      cos_o[l] = xc[TW-1:0];
      sin_o[l] = ysn[TW-1:0];
    end
  end

  assign valid_o = v_q[CordicSteps-1];
  assign side_o  = s_q[CordicSteps-1];

endmodule

`default_nettype wire

// ----- design/ezr_dcm.sv -----
`default_nettype none

module ezr_dcm import ezr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [TW-1:0] sin_i [3],  // roll, pitch, yaw
  input  logic signed [TW-1:0] cos_i [3],
  output logic                 valid_o,
  output side_t                side_o,
  output logic signed [MW-1:0] m_o [3][3]
);

  // stage 1: products of two trig terms
  logic v1_q;
  side_t s1_q;
  logic signed [TW-1:0] sasb_q, casb_q, m00_q, m01_q, casg_q, cacg_q;
  logic signed [TW-1:0] m12_q, sasg_q, cgsa_q, m22_q, sb_q, sg_q, cg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= side_i;
      sasb_q <= mul30(sin_i[0], sin_i[1]);
      casb_q <= mul30(cos_i[0], sin_i[1]);
      m00_q  <= mul30(cos_i[1], cos_i[2]);
      m01_q  <= mul30(cos_i[1], sin_i[2]);
      casg_q <= mul30(cos_i[0], sin_i[2]);
      cacg_q <= mul30(cos_i[0], cos_i[2]);
      m12_q  <= mul30(cos_i[1], sin_i[0]);
      sasg_q <= mul30(sin_i[0], sin_i[2]);
      cgsa_q <= mul30(cos_i[2], sin_i[0]);
      m22_q  <= mul30(cos_i[0], cos_i[1]);
      sb_q   <= sin_i[1];
      sg_q   <= sin_i[2];
      cg_q   <= cos_i[2];
    end
  end

  // stage 2: products with the yaw terms
  logic v2_q;
  side_t s2_q;
  logic signed [TW-1:0] p10_q, p11_q, p20_q, p21_q;
  logic signed [TW-1:0] m00_2_q, m01_2_q, casg_2_q, cacg_2_q;
  logic signed [TW-1:0] m12_2_q, sasg_2_q, cgsa_2_q, m22_2_q, sb_2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q     <= s1_q;
      p10_q    <= mul30(sasb_q, cg_q);
      p11_q    <= mul30(sasb_q, sg_q);
      p20_q    <= mul30(casb_q, cg_q);
      p21_q    <= mul30(casb_q, sg_q);
      m00_2_q  <= m00_q;
      m01_2_q  <= m01_q;
      casg_2_q <= casg_q;
      cacg_2_q <= cacg_q;
      m12_2_q  <= m12_q;
      sasg_2_q <= sasg_q;
      cgsa_2_q <= cgsa_q;
      m22_2_q  <= m22_q;
      sb_2_q   <= sb_q;
    end
  end

  // stage 3: sums
  logic v3_q;
  side_t s3_q;
  logic signed [MW-1:0] m_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q       <= s2_q;
      m_q[0][0]  <= MW'(m00_2_q);
      m_q[0][1]  <= MW'(m01_2_q);
      m_q[0][2]  <= -MW'(sb_2_q);
      m_q[1][0]  <= MW'(p10_q) - MW'(casg_2_q);
      m_q[1][1]  <= MW'(cacg_2_q) + MW'(p11_q);
      m_q[1][2]  <= MW'(m12_2_q);
      m_q[2][0]  <= MW'(sasg_2_q) + MW'(p20_q);
      m_q[2][1]  <= MW'(p21_q) - MW'(cgsa_2_q);
      m_q[2][2]  <= MW'(m22_2_q);
    end
  end

  assign valid_o = v3_q;
  assign side_o  = s3_q;
  assign m_o     = m_q;

endmodule

`default_nettype wire

// ----- design/ezr_rotate.sv -----
`default_nettype none

module ezr_rotate import ezr_pkg::*; #(
  parameter int VectorWidth = VectorWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic signed [MW-1:0] m_i [3][3],
  output logic                 valid_o,
  output logic signed [VW-1:0] res_o [3],
  output logic                 sat_o
);

  localparam int PW = MW + VW;
  localparam int AccW = PW + 2;
  localparam int RW = AccW - 30;
  localparam int OutBits = (VectorWidth < 32) ? VectorWidth : 32;
  localparam logic signed [RW-1:0] LimHi = $signed(RW'((65'sd1 <<< (OutBits - 1)) - 65'sd1));
  localparam logic signed [RW-1:0] LimLo = -LimHi - RW'(1);

  // stage 1: coefficient times component
  logic v1_q;
  logic signed [PW-1:0] p_q [3][3];
  logic signed [VW-1:0] vec [3];

  assign vec[0] = side_i.x;
  assign vec[1] = side_i.y;
  assign vec[2] = side_i.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p_q[r][k] <= PW'(side_i.to_body ? m_i[r][k] : m_i[k][r]) * PW'(vec[k]);
        end
      end
    end
  end

  // stage 2: exact sum and rounding to Q16.16
  logic v2_q;
  logic signed [RW-1:0] s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [AccW-1:0] acc;
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        acc = AccW'(p_q[r][0]) + AccW'(p_q[r][1]) + AccW'(p_q[r][2])
            + $signed(AccW'(1 << 29));
        s_q[r] <= acc[AccW-1:30];
      end
    end
  end

  // stage 3: saturation into the output register
  logic v3_q;
  logic signed [VW-1:0] res_q [3];
  logic sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic any;
    logic signed [RW-1:0] c;
    if (en_i) begin
      any = 1'b0;
      for (int r = 0; r < 3; r++) begin
        c = s_q[r];
        if (s_q[r] > LimHi) begin
          c = LimHi;
          any = 1'b1;
        end else if (s_q[r] < LimLo) begin
          c = LimLo;
          any = 1'b1;
        end
        res_q[r] <= c[VW-1:0];
      end
      sat_q <= any;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;
  assign sat_o   = sat_q;

endmodule

`default_nettype wire

// ----- design/euler_zyx_vector_rotation.sv -----
// 3-2-1 euler rotation of a Q16.16 vector by roll, pitch and yaw given in
// hundredths of a degree; any 16-bit angle wraps modulo 360 degrees.
// input channel: valid_i / stall_o carry the mode bit, the three angles and
// the vector; a transfer happens on a clock edge with valid_i high and
// stall_o low. to_body_i high gives matrix times vector, low the transpose.
// output channel: valid_o / stall_i carry the rotated vector and the
// saturation flag, set when any component was clipped.
// one transfer in per cycle sustained while the receiver does not stall,
// one result per item, in order. pipeline: three stages of angle conversion,
// one stage per cordic rotation, three for the matrix and three for the
// multiply, sum and saturation.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and stall_o rises in the same cycle; nothing is lost or repeated.
// reset clears all valid bits; no result is presented until an item has
// passed through the full pipeline.
`default_nettype none

module euler_zyx_vector_rotation import ezr_pkg::*; #(
  parameter int CordicSteps = CordicStepsDefault,
  parameter int VectorWidth = VectorWidthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic                 to_body_i,
  input  logic signed [15:0]   roll_angle_i,
  input  logic signed [15:0]   pitch_angle_i,
  input  logic signed [15:0]   yaw_angle_i,
  input  logic signed [VW-1:0] vec_x_i,
  input  logic signed [VW-1:0] vec_y_i,
  input  logic signed [VW-1:0] vec_z_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [VW-1:0] out_x_o,
  output logic signed [VW-1:0] out_y_o,
  output logic signed [VW-1:0] out_z_o,
  output logic                 saturated_o
);

  logic en;
  assign en = !(valid_o && stall_i);
  assign stall_o = !en;

  side_t side_in;
  logic signed [15:0] ang [3];

  assign side_in.to_body = to_body_i;
  assign side_in.x = vec_x_i;
  assign side_in.y = vec_y_i;
  assign side_in.z = vec_z_i;
  assign ang[0] = roll_angle_i;
  assign ang[1] = pitch_angle_i;
  assign ang[2] = yaw_angle_i;

  logic                 va;
  side_t                sa;
  logic signed [ZW-1:0] z [3];
  logic                 flip [3];

  ezr_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .side_i  (side_in),
    .ang_i   (ang),
    .valid_o (va),
    .side_o  (sa),
    .z_o     (z),
    .flip_o  (flip)
  );

  logic                 vc;
  side_t                sc;
  logic signed [TW-1:0] sin_v [3];
  logic signed [TW-1:0] cos_v [3];

  ezr_cordic #(
    .CordicSteps (CordicSteps)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va),
    .side_i  (sa),
    .z_i     (z),
    .flip_i  (flip),
    .valid_o (vc),
    .side_o  (sc),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  logic                 vm;
  side_t                sm;
  logic signed [MW-1:0] m [3][3];

  ezr_dcm u_dcm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc),
    .side_i  (sc),
    .sin_i   (sin_v),
    .cos_i   (cos_v),
    .valid_o (vm),
    .side_o  (sm),
    .m_o     (m)
  );

  logic signed [VW-1:0] res [3];

  ezr_rotate #(
    .VectorWidth (VectorWidth)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vm),
    .side_i  (sm),
    .m_i     (m),
    .valid_o (valid_o),
    .res_o   (res),
    .sat_o   (saturated_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

endmodule

`default_nettype wire
